/* hw/rtl/gyro_tilt_gesture_detector_core_defines.svh */
// ----------------------------------------------------------------------------
// Gyro tilt gesture detector assertion macros
// Shared concurrent assertion forms. They are clocked on the rising edge and
// held off while the synchronous reset is asserted.
// ----------------------------------------------------------------------------
`ifndef GYRO_TILT_GESTURE_DETECTOR_CORE_DEFINES_SVH
`define GYRO_TILT_GESTURE_DETECTOR_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GTGD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GTGD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/gtgd_pkg.sv */
// ----------------------------------------------------------------------------
// Gyro tilt gesture detector package
// Widths, codes, register map and the structs shared by the detector modules.
// ----------------------------------------------------------------------------
package gtgd_pkg;

  // Timestamp arithmetic width; differences wrap modulo 2**TIME_BITS.
  localparam int TIME_BITS = 32;
  localparam int NOW_W     = 32;
  localparam int RATE_W    = 16;
  localparam int CNT_W     = 8;
  localparam int CFG16_W   = 16;
  localparam int SUM_W     = 24;
  // The bias is a quotient of the sum and can span its full range when the
  // sample count is lowered while a calibration is under way.
  localparam int BIAS_W    = SUM_W;
  // Bias-corrected rate and its negation need two bits above the bias.
  localparam int AXIS_W    = BIAS_W + 2;

  // Shift-subtract divider: one quotient bit per step.
  localparam int DIV_STEPS = SUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Configuration port.
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 5;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_POLL_INTERVAL = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SETTLE        = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CALIB_COUNT   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_RATE_THRESH   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_NEUTRAL_RATE  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_COOLDOWN      = 3'd5;

  localparam logic [CFG16_W-1:0] RST_POLL_INTERVAL = 16'd20;
  localparam logic [CFG16_W-1:0] RST_SETTLE        = 16'd200;
  localparam logic [CNT_W-1:0]   RST_CALIB_COUNT   = 8'd32;
  localparam logic [CFG16_W-1:0] RST_RATE_THRESH   = 16'd3840;
  localparam logic [CFG16_W-1:0] RST_NEUTRAL_RATE  = 16'd1280;
  localparam logic [CFG16_W-1:0] RST_COOLDOWN      = 16'd500;

  // Event codes.
  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_FWD  = 2'd1;
  localparam logic [1:0] EV_BACK = 2'd2;

  // Screen orientation codes.
  localparam logic [1:0] ORIENT_PORTRAIT = 2'd0;
  localparam logic [1:0] ORIENT_LAND_CW  = 2'd1;
  localparam logic [1:0] ORIENT_INVERTED = 2'd2;
  localparam logic [1:0] ORIENT_LAND_CCW = 2'd3;

  typedef struct packed {
    logic [CFG16_W-1:0] poll_ms;
    logic [CFG16_W-1:0] settle_ms;
    logic [CNT_W-1:0]   calib_count;
    logic [CFG16_W-1:0] rate_threshold;
    logic [CFG16_W-1:0] neutral_rate;
    logic [CFG16_W-1:0] rearm_ms;
  } cfg_t;

  typedef struct packed {
    logic [NOW_W-1:0]         now_ms;
    logic                     enable;
    logic [1:0]               orientation;
    logic                     sample_ok;
    logic signed [RATE_W-1:0] rate_x;
    logic signed [RATE_W-1:0] rate_y;
  } in_item_t;

  typedef struct packed {
    logic [1:0] tilt_event;
    logic       is_awake;
    logic       is_calibrated;
    logic       tilt_held;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;
    logic eval;
    logic div_step;
    logic div_last;
    logic push;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic need_div;
  } dp_sts_t;

endpackage

/* hw/rtl/gtgd_if.sv */
// ----------------------------------------------------------------------------
// Gyro tilt gesture detector channels
// Valid/ready channels for the input samples and for the results.
// ----------------------------------------------------------------------------
interface gtgd_in_if;
  import gtgd_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [NOW_W-1:0]         now_ms;
  logic                     enable;
  logic [1:0]               orientation;
  logic                     sample_ok;
  logic signed [RATE_W-1:0] rate_x;
  logic signed [RATE_W-1:0] rate_y;

  modport source (
    output valid, now_ms, enable, orientation, sample_ok, rate_x, rate_y,
    input  ready
  );
  modport sink (
    input  valid, now_ms, enable, orientation, sample_ok, rate_x, rate_y,
    output ready
  );
endinterface

interface gtgd_out_if;
  import gtgd_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] tilt_event;
  logic       is_awake;
  logic       is_calibrated;
  logic       tilt_held;

  modport source (
    output valid, tilt_event, is_awake, is_calibrated, tilt_held,
    input  ready
  );
  modport sink (
    input  valid, tilt_event, is_awake, is_calibrated, tilt_held,
    output ready
  );
endinterface

/* hw/rtl/gyro_tilt_gesture_detector_core.sv */
// ----------------------------------------------------------------------------
// Gyro tilt gesture detector core
// Wake/sleep control, gyro bias calibration and forward/back tilt detection.
// ----------------------------------------------------------------------------
// Each accepted sample produces exactly one result, in order. The core works
// on one sample at a time: a sample is captured, evaluated and loaded into
// the output register, and for the sample that completes calibration a
// shift-subtract divider runs after evaluation, producing one quotient bit
// per cycle for both axes at once, before loading. The output register sits
// between the two sides, so the next sample is accepted while a finished
// result still waits to be taken; a result that finds the output register
// full waits until it drains. Configuration is written through an APB-style
// port (registers at byte offsets 0x00..0x14) and should only change while
// no sample is in flight.
// ----------------------------------------------------------------------------
`include "gyro_tilt_gesture_detector_core_defines.svh"

module gyro_tilt_gesture_detector_core (
  input  logic                            clk,
  input  logic                            rst_n,
  gtgd_in_if.sink                         in_ch,
  gtgd_out_if.source                      out_ch,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [gtgd_pkg::APB_ADDR_W-1:0] cfg_paddr,
  input  logic [gtgd_pkg::APB_DATA_W-1:0] cfg_pwdata,
  output logic [gtgd_pkg::APB_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import gtgd_pkg::*;

  cfg_t      cfg;
  dp_cmd_t   cmd;
  dp_sts_t   sts;
  in_item_t  in_item;
  out_item_t out_item;

  // Configuration registers. Reads return the stored value; unused offsets
  // read as zero and ignore writes.
  gtgd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // The controller owns both handshakes. It takes a sample only when idle,
  // then steps the datapath through evaluation and, when calibration just
  // finished, the bias division.
  gtgd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  assign in_item = '{now_ms:      in_ch.now_ms,
                     enable:      in_ch.enable,
                     orientation: in_ch.orientation,
                     sample_ok:   in_ch.sample_ok,
                     rate_x:      in_ch.rate_x,
                     rate_y:      in_ch.rate_y};

  // The datapath keeps the detector state. The status flags of a result are
  // the state after its sample, read from the state registers at hand-off.
  gtgd_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .cmd      (cmd),
    .sts      (sts),
    .in_item  (in_item),
    .out_item (out_item)
  );

  assign out_ch.tilt_event    = out_item.tilt_event;
  assign out_ch.is_awake      = out_item.is_awake;
  assign out_ch.is_calibrated = out_item.is_calibrated;
  assign out_ch.tilt_held     = out_item.tilt_held;

  // A reported tilt always leaves the detector awake, calibrated and holding.
  `GTGD_ASSERT_IMP(a_event_state, clk, rst_n, out_ch.valid && out_ch.tilt_event != EV_NONE, out_ch.tilt_held && out_ch.is_calibrated && out_ch.is_awake, "tilt reported outside held calibrated state")
  // Sleeping clears calibration and any held tilt.
  `GTGD_ASSERT_IMP(a_sleep_clears, clk, rst_n, out_ch.valid && !out_ch.is_awake, !out_ch.is_calibrated && !out_ch.tilt_held, "asleep with calibration or held tilt")
  // Only the three defined event codes are ever produced.
  `GTGD_ASSERT_IMP(a_event_code, clk, rst_n, out_ch.valid, out_ch.tilt_event == EV_NONE || out_ch.tilt_event == EV_FWD || out_ch.tilt_event == EV_BACK, "undefined tilt event code")
  // A transfer on the input starts work, so the core is busy on the next cycle.
  `GTGD_ASSERT_NXT(a_busy_after_take, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready, "input taken while a sample is in flight")

endmodule

/* hw/rtl/gtgd_regs.sv */
// ----------------------------------------------------------------------------
// Gyro tilt gesture detector register file
// APB-style configuration registers with read-back.
// ----------------------------------------------------------------------------
module gtgd_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [gtgd_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [gtgd_pkg::APB_DATA_W-1:0] pwdata,
  output logic [gtgd_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  output gtgd_pkg::cfg_t                  cfg
);
  import gtgd_pkg::*;

  cfg_t                 cfg_r;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[APB_ADDR_W-1:2];
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.poll_ms        <= RST_POLL_INTERVAL;
      cfg_r.settle_ms      <= RST_SETTLE;
      cfg_r.calib_count    <= RST_CALIB_COUNT;
      cfg_r.rate_threshold <= RST_RATE_THRESH;
      cfg_r.neutral_rate   <= RST_NEUTRAL_RATE;
      cfg_r.rearm_ms       <= RST_COOLDOWN;
    end else if (wr_en) begin
      case (idx)
        REG_POLL_INTERVAL: cfg_r.poll_ms        <= pwdata[CFG16_W-1:0];
        REG_SETTLE:        cfg_r.settle_ms      <= pwdata[CFG16_W-1:0];
        REG_CALIB_COUNT:   cfg_r.calib_count    <= pwdata[CNT_W-1:0];
        REG_RATE_THRESH:   cfg_r.rate_threshold <= pwdata[CFG16_W-1:0];
        REG_NEUTRAL_RATE:  cfg_r.neutral_rate   <= pwdata[CFG16_W-1:0];
        REG_COOLDOWN:      cfg_r.rearm_ms       <= pwdata[CFG16_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_POLL_INTERVAL: prdata = APB_DATA_W'(cfg_r.poll_ms);
      REG_SETTLE:        prdata = APB_DATA_W'(cfg_r.settle_ms);
      REG_CALIB_COUNT:   prdata = APB_DATA_W'(cfg_r.calib_count);
      REG_RATE_THRESH:   prdata = APB_DATA_W'(cfg_r.rate_threshold);
      REG_NEUTRAL_RATE:  prdata = APB_DATA_W'(cfg_r.neutral_rate);
      REG_COOLDOWN:      prdata = APB_DATA_W'(cfg_r.rearm_ms);
      default:           prdata = '0;
    endcase
  end

endmodule

/* hw/rtl/gtgd_ctrl.sv */
// ----------------------------------------------------------------------------
// Gyro tilt gesture detector controller
// Sequences capture, evaluation, bias division and result hand-off.
// ----------------------------------------------------------------------------
module gtgd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  gtgd_pkg::dp_sts_t sts,
  output gtgd_pkg::dp_cmd_t cmd
);
  import gtgd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EVAL = 4'b0010,
    S_DIV  = 4'b0100,
    S_PUSH = 4'b1000
  } state_t;

  state_t               state_r, state_nxt;
  logic [DIV_CNT_W-1:0] step_r, step_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  // The output register can take a new result if empty or emptied this cycle.
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (sts.need_div) begin
          step_nxt  = DIV_CNT_W'(DIV_STEPS - 1);
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_PUSH;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (step_r == '0) begin
          cmd.div_last = 1'b1;
          state_nxt    = S_PUSH;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      S_PUSH: begin
        if (out_free) begin
          cmd.push      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* hw/rtl/gtgd_dp.sv */
// ----------------------------------------------------------------------------
// Gyro tilt gesture detector datapath
// Detector state, calibration sums, bias divider and tilt decision logic.
// ----------------------------------------------------------------------------
module gtgd_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  gtgd_pkg::cfg_t      cfg,
  input  gtgd_pkg::dp_cmd_t   cmd,
  output gtgd_pkg::dp_sts_t   sts,
  input  gtgd_pkg::in_item_t  in_item,
  output gtgd_pkg::out_item_t out_item
);
  import gtgd_pkg::*;

  // Captured input and registered result.
  in_item_t  item_r;
  out_item_t out_r;

  // Detector state.
  logic                     awake_r, holding_r, calib_done_r;
  logic [TIME_BITS-1:0]     last_poll_r, last_tilt_r, wake_r;
  logic [CNT_W-1:0]         calib_seen_r;
  logic signed [SUM_W-1:0]  sum_x_r, sum_y_r;
  logic signed [BIAS_W-1:0] bias_x_r, bias_y_r;
  logic [1:0]               ev_r;

  // Divider lanes: lane 0 is X, lane 1 is Y.
  logic [SUM_W-1:0] dq_r   [2];
  logic [CNT_W-1:0] drem_r [2];
  logic             dneg_r [2];
  logic [CNT_W-1:0] ddvs_r;
  logic [SUM_W-1:0] dq_nxt   [2];
  logic [CNT_W-1:0] drem_nxt [2];
  logic [CNT_W:0]   dtrial   [2];
  logic [CNT_W:0]   ddiff    [2];
  logic [BIAS_W-1:0] dres    [2];

  // Evaluation terms.
  logic [TIME_BITS-1:0]     now, el_poll, el_wake, el_tilt;
  logic                     en, wake, sleep_req, poll_pass, settle_pass, cool_pass;
  logic signed [SUM_W-1:0]  sum_x_add, sum_y_add;
  logic [SUM_W-1:0]         mag_x_sum, mag_y_sum;
  logic [CNT_W-1:0]         cnt, seen_inc;
  logic                     calib_step, finish;
  logic signed [AXIS_W-1:0] cx, cy, axis, mag, thr_s, neu_s;
  logic                     over, under, rel_ok;

  always_comb begin
    now         = item_r.now_ms[TIME_BITS-1:0];
    el_poll     = now - last_poll_r;
    el_wake     = now - wake_r;
    el_tilt     = now - last_tilt_r;
    en          = item_r.enable;
    wake        = en && !awake_r;
    sleep_req   = !en && awake_r;
    poll_pass   = el_poll >= TIME_BITS'(cfg.poll_ms);
    settle_pass = el_wake >= TIME_BITS'(cfg.settle_ms);
    cool_pass   = el_tilt >= TIME_BITS'(cfg.rearm_ms);

    sum_x_add = sum_x_r + SUM_W'(item_r.rate_x);
    sum_y_add = sum_y_r + SUM_W'(item_r.rate_y);
    mag_x_sum = sum_x_add[SUM_W-1] ? SUM_W'(-sum_x_add) : SUM_W'(sum_x_add);
    mag_y_sum = sum_y_add[SUM_W-1] ? SUM_W'(-sum_y_add) : SUM_W'(sum_y_add);
    // A zero sample count behaves as one.
    cnt        = (cfg.calib_count == '0) ? CNT_W'(1) : cfg.calib_count;
    seen_inc   = calib_seen_r + 1'b1;
    calib_step = en && awake_r && poll_pass && item_r.sample_ok && settle_pass &&
                 !calib_done_r;
    finish     = calib_step && (seen_inc >= cnt);

    cx = AXIS_W'(item_r.rate_x) - AXIS_W'(bias_x_r);
    cy = AXIS_W'(item_r.rate_y) - AXIS_W'(bias_y_r);
    case (item_r.orientation)
      ORIENT_LAND_CW:  axis = cy;
      ORIENT_INVERTED: axis = cx;
      ORIENT_LAND_CCW: axis = -cy;
      default:         axis = -cx;
    endcase
    mag    = axis[AXIS_W-1] ? -axis : axis;
    thr_s  = $signed(AXIS_W'(cfg.rate_threshold));
    neu_s  = $signed(AXIS_W'(cfg.neutral_rate));
    over   = axis > thr_s;
    under  = axis < -thr_s;
    rel_ok = mag < neu_s;
  end

  assign sts.need_div = finish;
  assign out_item     = out_r;

  // One restoring-division step per lane.
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      dtrial[i]   = {drem_r[i], dq_r[i][SUM_W-1]};
      ddiff[i]    = dtrial[i] - {1'b0, ddvs_r};
      if (dtrial[i] >= {1'b0, ddvs_r}) begin
        drem_nxt[i] = ddiff[i][CNT_W-1:0];
        dq_nxt[i]   = {dq_r[i][SUM_W-2:0], 1'b1};
      end else begin
        drem_nxt[i] = dtrial[i][CNT_W-1:0];
        dq_nxt[i]   = {dq_r[i][SUM_W-2:0], 1'b0};
      end
      // The quotient magnitude never exceeds the sum's, so it fits the bias.
      dres[i] = dneg_r[i] ? BIAS_W'(-dq_nxt[i]) : BIAS_W'(dq_nxt[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_item;
    end
    if (cmd.push) begin
      out_r <= '{tilt_event: ev_r, is_awake: awake_r, is_calibrated: calib_done_r,
                 tilt_held: holding_r};
    end
    if (cmd.eval && finish) begin
      dq_r[0]   <= mag_x_sum;
      dq_r[1]   <= mag_y_sum;
      dneg_r[0] <= sum_x_add[SUM_W-1];
      dneg_r[1] <= sum_y_add[SUM_W-1];
      drem_r[0] <= '0;
      drem_r[1] <= '0;
      ddvs_r    <= cnt;
    end else if (cmd.div_step) begin
      dq_r[0]   <= dq_nxt[0];
      dq_r[1]   <= dq_nxt[1];
      drem_r[0] <= drem_nxt[0];
      drem_r[1] <= drem_nxt[1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awake_r      <= 1'b0;
      holding_r    <= 1'b0;
      calib_done_r <= 1'b0;
      last_poll_r  <= '0;
      last_tilt_r  <= '0;
      wake_r       <= '0;
      calib_seen_r <= '0;
      sum_x_r      <= '0;
      sum_y_r      <= '0;
      bias_x_r     <= '0;
      bias_y_r     <= '0;
      ev_r         <= EV_NONE;
    end else begin
      if (cmd.eval) begin
        ev_r <= EV_NONE;
        if (wake) begin
          awake_r      <= 1'b1;
          last_poll_r  <= now;
          last_tilt_r  <= now;
          wake_r       <= now;
          calib_done_r <= 1'b0;
          calib_seen_r <= '0;
          sum_x_r      <= '0;
          sum_y_r      <= '0;
          bias_x_r     <= '0;
          bias_y_r     <= '0;
        end else if (sleep_req) begin
          awake_r      <= 1'b0;
          holding_r    <= 1'b0;
          calib_done_r <= 1'b0;
          calib_seen_r <= '0;
          sum_x_r      <= '0;
          sum_y_r      <= '0;
          bias_x_r     <= '0;
          bias_y_r     <= '0;
        end else if (en && poll_pass) begin
          last_poll_r <= now;
          if (item_r.sample_ok && settle_pass) begin
            if (!calib_done_r) begin
              sum_x_r      <= sum_x_add;
              sum_y_r      <= sum_y_add;
              calib_seen_r <= seen_inc;
              if (finish) begin
                calib_done_r <= 1'b1;
              end
            end else if (holding_r) begin
              if (rel_ok) begin
                holding_r <= 1'b0;
              end
            end else if (cool_pass) begin
              if (over) begin
                holding_r   <= 1'b1;
                last_tilt_r <= now;
                ev_r        <= EV_FWD;
              end else if (under) begin
                holding_r   <= 1'b1;
                last_tilt_r <= now;
                ev_r        <= EV_BACK;
              end
            end
          end
        end
      end
      if (cmd.div_step && cmd.div_last) begin
        bias_x_r <= $signed(dres[0]);
        bias_y_r <= $signed(dres[1]);
      end
    end
  end

endmodule
